// ----- hw/rtl/drp_pkg.sv -----
// shared types, constants and helpers for the dhcp reply parser
// no dependencies; imported by every module of the block
package drp_pkg;

    localparam int HEADER_BYTES      = 236;
    localparam int OPTION_AREA_BYTES = 312;
    localparam int TOTAL_BYTES       = HEADER_BYTES + OPTION_AREA_BYTES;
    localparam int OFF_W             = $clog2(TOTAL_BYTES + 1);
    localparam int OPT_W             = $clog2(OPTION_AREA_BYTES);
    localparam int SUM_W             = ((OPT_W > 8) ? OPT_W : 8) + 1;
    localparam int TICK_W            = 20;
    localparam int PROD_W            = 32 + TICK_W;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);
    localparam int VIDX_W            = 3;
    localparam int TDATA_W           = 152;

    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 20'd1000;

    localparam logic [7:0] OP_BOOTREPLY = 8'd2;
    localparam logic [7:0] OPT_PAD      = 8'd0;
    localparam logic [7:0] OPT_END      = 8'd255;
    localparam logic [7:0] OPT_TYPE     = 8'd53;
    localparam logic [7:0] OPT_LEASE    = 8'd51;
    localparam logic [7:0] OPT_SUBNET   = 8'd1;
    localparam logic [7:0] OPT_ROUTER   = 8'd3;
    localparam logic [7:0] ADDR_BYTES   = 8'd4;

    localparam logic [OFF_W-1:0] YIADDR_FIRST = OFF_W'(16);
    localparam logic [OFF_W-1:0] YIADDR_END   = OFF_W'(20);

    // tracked options, one bit each in a hit vector
    localparam int K_TYPE   = 0;
    localparam int K_LEASE  = 1;
    localparam int K_SUBNET = 2;
    localparam int K_ROUTER = 3;
    localparam int NUM_OPTS = 4;

    localparam logic [2:0] HS_OK         = 3'd0;
    localparam logic [2:0] HS_BAD_OP     = 3'd1;
    localparam logic [2:0] HS_NO_COOKIE  = 3'd2;
    localparam logic [2:0] HS_NO_TYPE    = 3'd3;
    localparam logic [2:0] HS_BAD_TYPE   = 3'd4;

    localparam logic [1:0] OS_OK      = 2'd0;
    localparam logic [1:0] OS_MISSING = 2'd1;
    localparam logic [1:0] OS_BAD     = 2'd2;

    typedef enum logic [3:0] {
        PH_CODE  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DONE  = 4'b1000
    } walk_phase_t;

    typedef enum logic [3:0] {
        CS_NONE = 4'b0001,
        CS_BUSY = 4'b0010,
        CS_OK   = 4'b0100,
        CS_BAD  = 4'b1000
    } cap_st_t;

    typedef struct packed {
        logic [2:0]  header_status;
        logic [7:0]  message_type;
        logic [31:0] your_ip;
        logic [1:0]  lease_status;
        logic [31:0] lease_sec;
        logic [1:0]  subnet_status;
        logic [31:0] subnet_mask;
        logic [1:0]  router_status;
        logic [31:0] router_ip;
    } drp_result_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0:    v = 8'h63;
            2'd1:    v = 8'h82;
            2'd2:    v = 8'h53;
            default: v = 8'h63;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] opt_status(input cap_st_t st);
        logic [1:0] v;
        unique case (st)
            CS_OK:   v = OS_OK;
            CS_NONE: v = OS_MISSING;
            default: v = OS_BAD;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/drp_front.sv -----
// front end: accepts message bytes, walks header and option tlvs,
// pushes one summary record per message; uses drp_pkg
module drp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic                 q_full,
    output logic                 q_push,
    output drp_pkg::drp_result_t q_data
);
    import drp_pkg::*;

    logic [OFF_W-1:0]  off_reg, off_next;
    walk_phase_t       phase_reg, phase_next;
    logic [NUM_OPTS-1:0] hit_reg, hit_next;
    logic [7:0]        left_reg, left_next;
    logic [VIDX_W-1:0] vidx_reg, vidx_next;
    logic              opc_reg, opc_next;
    logic              cookie_reg, cookie_next;
    cap_st_t           st_reg [NUM_OPTS];
    cap_st_t           st_next [NUM_OPTS];
    cap_st_t           st_close [NUM_OPTS];
    logic [31:0]       val_reg [NUM_OPTS];
    logic [31:0]       val_next [NUM_OPTS];
    logic [31:0]       yi_reg, yi_next;

    logic              accept;
    logic              in_opt;
    logic [OFF_W-1:0]  opt_full;
    logic [OPT_W-1:0]  opt_off;
    logic [SUM_W-1:0]  end_sum;
    logic              overrun;
    logic [NUM_OPTS-1:0] len_ok;
    logic [NUM_OPTS-1:0] code_hit;
    logic [1:0]        lease_os, subnet_os, router_os;
    logic [2:0]        hs;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && in_last;

    assign in_opt   = (off_reg >= OFF_W'(HEADER_BYTES)) && (off_reg < OFF_W'(TOTAL_BYTES));
    assign opt_full = off_reg - OFF_W'(HEADER_BYTES);
    assign opt_off  = opt_full[OPT_W-1:0];
    assign end_sum  = SUM_W'(opt_off) + SUM_W'(in_byte);
    assign overrun  = end_sum >= SUM_W'(OPTION_AREA_BYTES);

    assign code_hit[K_TYPE]   = (in_byte == OPT_TYPE);
    assign code_hit[K_LEASE]  = (in_byte == OPT_LEASE);
    assign code_hit[K_SUBNET] = (in_byte == OPT_SUBNET);
    assign code_hit[K_ROUTER] = (in_byte == OPT_ROUTER);

    assign len_ok[K_TYPE]   = (in_byte == 8'd1);
    assign len_ok[K_LEASE]  = (in_byte == ADDR_BYTES);
    assign len_ok[K_SUBNET] = (in_byte == ADDR_BYTES);
    assign len_ok[K_ROUTER] = (in_byte != 8'd0) && (in_byte[1:0] == 2'b00);

    always_comb
    begin
        off_next    = off_reg;
        phase_next  = phase_reg;
        hit_next    = hit_reg;
        left_next   = left_reg;
        vidx_next   = vidx_reg;
        opc_next    = opc_reg;
        cookie_next = cookie_reg;
        yi_next     = yi_reg;
        for (int k = 0; k < NUM_OPTS; k++)
        begin
            st_next[k]  = st_reg[k];
            val_next[k] = val_reg[k];
        end

        if (off_reg == '0)
        begin
            opc_next = (in_byte == OP_BOOTREPLY);
        end
        if ((off_reg >= YIADDR_FIRST) && (off_reg < YIADDR_END))
        begin
            yi_next = {yi_reg[23:0], in_byte};
        end
        if (off_reg < OFF_W'(TOTAL_BYTES))
        begin
            off_next = off_reg + OFF_W'(1);
        end

        if (in_opt)
        begin
            if (opt_off < OPT_W'(4))
            begin
                if (opt_off == '0)
                    cookie_next = (in_byte == cookie_byte(opt_off[1:0]));
                else
                    cookie_next = cookie_reg && (in_byte == cookie_byte(opt_off[1:0]));
            end
            else
            begin
                unique case (phase_reg)
                    PH_CODE:
                    begin
                        if (in_byte == OPT_END)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (in_byte != OPT_PAD)
                        begin
                            hit_next   = code_hit;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        for (int k = 0; k < NUM_OPTS; k++)
                        begin
                            if (hit_reg[k] && (st_reg[k] == CS_NONE))
                            begin
                                st_next[k]  = (overrun || !len_ok[k]) ? CS_BAD : CS_BUSY;
                                val_next[k] = '0;
                            end
                        end
                        left_next  = in_byte;
                        vidx_next  = '0;
                        phase_next = (in_byte != 8'd0) ? PH_VALUE : PH_CODE;
                    end
                    PH_VALUE:
                    begin
                        // only the first four value bytes are kept
                        for (int k = 0; k < NUM_OPTS; k++)
                        begin
                            if (hit_reg[k] && (st_reg[k] == CS_BUSY))
                            begin
                                if (vidx_reg < VIDX_W'(ADDR_BYTES))
                                    val_next[k] = {val_reg[k][23:0], in_byte};
                                if (left_reg == 8'd1)
                                    st_next[k] = CS_OK;
                            end
                        end
                        if (vidx_reg < VIDX_W'(ADDR_BYTES))
                            vidx_next = vidx_reg + VIDX_W'(1);
                        left_next = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                            phase_next = PH_CODE;
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = PH_CODE;
                    end
                endcase
            end
        end
    end

    // an option still open at the last item, or cut right after its code, is bad
    always_comb
    begin
        for (int k = 0; k < NUM_OPTS; k++)
        begin
            if ((st_next[k] == CS_BUSY) ||
                ((st_next[k] == CS_NONE) && (phase_next == PH_LEN) && hit_next[k]))
                st_close[k] = CS_BAD;
            else
                st_close[k] = st_next[k];
        end
    end

    always_comb
    begin
        priority if (!opc_next)
            hs = HS_BAD_OP;
        else if (!cookie_next)
            hs = HS_NO_COOKIE;
        else if (st_close[K_TYPE] == CS_NONE)
            hs = HS_NO_TYPE;
        else if (st_close[K_TYPE] != CS_OK)
            hs = HS_BAD_TYPE;
        else
            hs = HS_OK;
    end

    assign lease_os  = opt_status(st_close[K_LEASE]);
    assign subnet_os = opt_status(st_close[K_SUBNET]);
    assign router_os = opt_status(st_close[K_ROUTER]);

    always_comb
    begin
        q_data.header_status = hs;
        q_data.message_type  = (hs == HS_OK) ? val_next[K_TYPE][7:0] : 8'd0;
        q_data.your_ip       = yi_next;
        q_data.lease_status  = lease_os;
        q_data.lease_sec     = (lease_os == OS_OK) ? val_next[K_LEASE] : 32'd0;
        q_data.subnet_status = subnet_os;
        q_data.subnet_mask   = (subnet_os == OS_OK) ? val_next[K_SUBNET] : 32'd0;
        q_data.router_status = router_os;
        q_data.router_ip     = (router_os == OS_OK) ? val_next[K_ROUTER] : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg    <= '0;
            phase_reg  <= PH_CODE;
            hit_reg    <= '0;
            left_reg   <= '0;
            vidx_reg   <= '0;
            opc_reg    <= 1'b0;
            cookie_reg <= 1'b0;
            yi_reg     <= '0;
            for (int k = 0; k < NUM_OPTS; k++)
            begin
                st_reg[k]  <= CS_NONE;
                val_reg[k] <= '0;
            end
        end
        else if (accept)
        begin
            if (in_last)
            begin
                // message done: parser returns to its idle values
                off_reg    <= '0;
                phase_reg  <= PH_CODE;
                hit_reg    <= '0;
                left_reg   <= '0;
                vidx_reg   <= '0;
                opc_reg    <= 1'b0;
                cookie_reg <= 1'b0;
                yi_reg     <= '0;
                for (int k = 0; k < NUM_OPTS; k++)
                begin
                    st_reg[k]  <= CS_NONE;
                    val_reg[k] <= '0;
                end
            end
            else
            begin
                off_reg    <= off_next;
                phase_reg  <= phase_next;
                hit_reg    <= hit_next;
                left_reg   <= left_next;
                vidx_reg   <= vidx_next;
                opc_reg    <= opc_next;
                cookie_reg <= cookie_next;
                yi_reg     <= yi_next;
                for (int k = 0; k < NUM_OPTS; k++)
                begin
                    st_reg[k]  <= st_next[k];
                    val_reg[k] <= val_next[k];
                end
            end
        end
    end

endmodule

// ----- hw/rtl/drp_fifo.sv -----
// short record queue between the byte front end and the lease back end
// uses drp_pkg for the record type and depth
module drp_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  drp_pkg::drp_result_t push_data,
    input  logic                 pop,
    output drp_pkg::drp_result_t pop_data,
    output logic                 full,
    output logic                 empty
);
    import drp_pkg::*;

    drp_result_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg, wr_next;
    logic [FIFO_PTR_W-1:0] rd_reg, rd_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign full     = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = do_push ? wr_reg + FIFO_PTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + FIFO_PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + FIFO_CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - FIFO_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/drp_back.sv -----
// back end: derates the lease, scales it by the tick rate, saturates,
// and holds the result item in the output register; uses drp_pkg
module drp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [drp_pkg::TICK_W-1:0] tick_rate,
    input  logic                 q_empty,
    input  drp_pkg::drp_result_t q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [drp_pkg::TDATA_W-1:0] out_data
);
    import drp_pkg::*;

    logic              s1_v_reg, s2_v_reg, o_v_reg;
    drp_result_t       s1_reg, s2_reg;
    logic [31:0]       s1_sec_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [TDATA_W-1:0] o_data_reg, o_data_next;
    logic [31:0]       ticks;
    logic              o_adv, s2_adv, s1_adv;

    assign o_adv  = !o_v_reg || out_ready;
    assign s2_adv = !s2_v_reg || o_adv;
    assign s1_adv = !s1_v_reg || s2_adv;
    assign q_pop  = !q_empty && s1_adv;

    assign ticks = (|s2_prod_reg[PROD_W-1:32]) ? 32'hFFFF_FFFF : s2_prod_reg[31:0];

    always_comb
    begin
        o_data_next = '0;
        o_data_next[2:0]     = s2_reg.header_status;
        o_data_next[10:3]    = s2_reg.message_type;
        o_data_next[42:11]   = s2_reg.your_ip;
        o_data_next[44:43]   = s2_reg.lease_status;
        o_data_next[76:45]   = ticks;
        o_data_next[78:77]   = s2_reg.subnet_status;
        o_data_next[110:79]  = s2_reg.subnet_mask;
        o_data_next[112:111] = s2_reg.router_status;
        o_data_next[144:113] = s2_reg.router_ip;
    end

    assign out_valid = o_v_reg;
    assign out_data  = o_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_v_reg <= q_pop;
            if (s2_adv)
                s2_v_reg <= s1_v_reg;
            if (o_adv)
                o_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg     <= q_data;
            s1_sec_reg <= q_data.lease_sec - {3'b000, q_data.lease_sec[31:3]};
        end
        if (s2_adv && s1_v_reg)
        begin
            s2_reg      <= s1_reg;
            s2_prod_reg <= PROD_W'(s1_sec_reg) * PROD_W'(tick_rate);
        end
        if (o_adv && s2_v_reg)
            o_data_reg <= o_data_next;
    end

endmodule

// ----- hw/rtl/dhcp_reply_parser.sv -----
// top level of the dhcp reply parser: tick rate register, byte front end,
// record queue and lease back end; uses drp_pkg, drp_front, drp_fifo, drp_back
//
//  channel  dir  width  contents
//  s_*      in   8+1    tdata = rx_byte, tlast = last_byte
//  m_*      out  152    one result item per message (fields listed at m_tdata)
//  cfg_*    in   20     tick_rate write
//
// one message byte is taken every cycle; s_tready drops only when the
// four-entry record queue is full.
// after its last byte a result item passes the record queue, then the derate stage,
// the 32x20 multiply stage and saturation into the output register.
// rst_n clears the parser, queue and pipeline and sets tick_rate to 1000.
// m_tready low stalls the back end only; bytes keep flowing until the queue fills.
module dhcp_reply_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] rx_byte
    input  logic                         s_tlast,   // last_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] header_status, [10:3] message_type, [42:11] your_ip,
    // [44:43] lease_status, [76:45] lease_ticks, [78:77] subnet_status,
    // [110:79] subnet_mask, [112:111] router_status, [144:113] router_ip
    output logic [drp_pkg::TDATA_W-1:0]  m_tdata,
    input  logic                         cfg_we,
    input  logic [drp_pkg::TICK_W-1:0]   cfg_wdata
);
    import drp_pkg::*;

    logic [TICK_W-1:0] tick_rate_reg;
    logic              q_push, q_pop, q_full, q_empty;
    drp_result_t       q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_rate_reg <= TICK_RATE_RESET;
        else if (cfg_we)
            tick_rate_reg <= cfg_wdata;
    end

    drp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    drp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    drp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_rate (tick_rate_reg),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
